### rtl/rgbq_pkg.sv
package rgbq_pkg;

  typedef struct packed {
    logic [7:0] red_top_left;
    logic [7:0] green_top_left;
    logic [7:0] blue_top_left;
    logic [7:0] red_top_right;
    logic [7:0] green_top_right;
    logic [7:0] blue_top_right;
    logic [7:0] red_bottom_left;
    logic [7:0] green_bottom_left;
    logic [7:0] blue_bottom_left;
    logic [7:0] red_bottom_right;
    logic [7:0] green_bottom_right;
    logic [7:0] blue_bottom_right;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } ycc_t;

  // load enables of the three pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

  localparam logic [7:0] LUMA_KR     = 8'd66;
  localparam logic [7:0] LUMA_KG     = 8'd129;
  localparam logic [7:0] LUMA_KB     = 8'd25;
  localparam int         LUMA_SHIFT  = 8;
  localparam logic [7:0] LUMA_OFFSET = 8'd16;

  localparam logic [6:0] CB_KR = 7'd38;
  localparam logic [6:0] CB_KG = 7'd74;
  localparam logic [6:0] CB_KB = 7'd112;
  localparam logic [6:0] CR_KR = 7'd112;
  localparam logic [6:0] CR_KG = 7'd94;
  localparam logic [6:0] CR_KB = 7'd18;

  localparam int                CHROMA_SHIFT = 10;
  localparam logic signed [19:0] CHROMA_BIAS = 20'sd131072;

endpackage

### rtl/rgbq_luma.sv
module rgbq_luma (
  input  logic              clk,
  input  rgbq_pkg::adv_t    adv,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic [7:0]        luma
);

  logic [14:0] prod_r;
  logic [15:0] prod_g;
  logic [12:0] prod_b;
  logic [15:0] sum;
  logic [7:0]  luma_s2;

  assign sum = {1'b0, prod_r} + prod_g + {3'b000, prod_b};

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      prod_r <= {7'd0, red}   * {7'd0, rgbq_pkg::LUMA_KR};
      prod_g <= {8'd0, green} * {8'd0, rgbq_pkg::LUMA_KG};
      prod_b <= {5'd0, blue}  * {5'd0, rgbq_pkg::LUMA_KB};
    end
    if (adv.s2) begin
      luma_s2 <= sum[15:rgbq_pkg::LUMA_SHIFT] + rgbq_pkg::LUMA_OFFSET;
    end
    if (adv.s3) begin
      luma <= luma_s2;
    end
  end

endmodule

### rtl/rgbq_chroma.sv
module rgbq_chroma (
  input  logic              clk,
  input  rgbq_pkg::adv_t    adv,
  input  rgbq_pkg::pixel_t  pix,
  output logic [7:0]        chroma_blue,
  output logic [7:0]        chroma_red
);

  logic [9:0]  sum_r;
  logic [9:0]  sum_g;
  logic [9:0]  sum_b;
  logic [16:0] cb_r, cb_g, cb_b;
  logic [16:0] cr_r, cr_g, cr_b;
  logic signed [19:0] cb_t;
  logic signed [19:0] cr_t;

  // biased by 128 << 10 so the shift below gives floor + offset
  assign cb_t = rgbq_pkg::CHROMA_BIAS - $signed({3'b000, cb_r}) - $signed({3'b000, cb_g})
              + $signed({3'b000, cb_b});
  assign cr_t = rgbq_pkg::CHROMA_BIAS + $signed({3'b000, cr_r}) - $signed({3'b000, cr_g})
              - $signed({3'b000, cr_b});

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      sum_r <= {2'b00, pix.red_top_left} + {2'b00, pix.red_top_right}
             + {2'b00, pix.red_bottom_left} + {2'b00, pix.red_bottom_right};
      sum_g <= {2'b00, pix.green_top_left} + {2'b00, pix.green_top_right}
             + {2'b00, pix.green_bottom_left} + {2'b00, pix.green_bottom_right};
      sum_b <= {2'b00, pix.blue_top_left} + {2'b00, pix.blue_top_right}
             + {2'b00, pix.blue_bottom_left} + {2'b00, pix.blue_bottom_right};
    end
    if (adv.s2) begin
      cb_r <= {7'd0, sum_r} * {10'd0, rgbq_pkg::CB_KR};
      cb_g <= {7'd0, sum_g} * {10'd0, rgbq_pkg::CB_KG};
      cb_b <= {7'd0, sum_b} * {10'd0, rgbq_pkg::CB_KB};
      cr_r <= {7'd0, sum_r} * {10'd0, rgbq_pkg::CR_KR};
      cr_g <= {7'd0, sum_g} * {10'd0, rgbq_pkg::CR_KG};
      cr_b <= {7'd0, sum_b} * {10'd0, rgbq_pkg::CR_KB};
    end
    if (adv.s3) begin
      chroma_blue <= cb_t[19] ? 8'd0 : cb_t[17:rgbq_pkg::CHROMA_SHIFT];
      chroma_red  <= cr_t[19] ? 8'd0 : cr_t[17:rgbq_pkg::CHROMA_SHIFT];
    end
  end

endmodule

### rtl/rgb_quad_to_ycbcr_420_top.sv
// channel | valid       | stall       | payload                  | carries
// input   | pixel_valid | pixel_stall | pixel_data (pixel_t)     | rgb of one 2x2 quad
// output  | ycc_valid   | ycc_stall   | ycc_data (ycc_t)         | four luma, cb, cr
//
// three register stages: luma products and chroma sums, luma sums and chroma products, chroma combine
// one quad per cycle when the output is not stalled
// a stage loads whenever it is empty or the stage after it moves, so bubbles close up
// pixel_stall follows ycc_stall only once all three stages hold a quad
// rst clears the stage valid bits; data registers are not reset
module rgb_quad_to_ycbcr_420_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  rgbq_pkg::pixel_t  pixel_data,
  output logic              ycc_valid,
  input  logic              ycc_stall,
  output rgbq_pkg::ycc_t    ycc_data
);

  logic           v1;
  logic           v2;
  logic           v3;
  rgbq_pkg::adv_t adv;

  always_comb begin
    adv.s3 = !v3 || !ycc_stall;
    adv.s2 = !v2 || adv.s3;
    adv.s1 = !v1 || adv.s2;
  end

  assign pixel_stall = !adv.s1;
  assign ycc_valid   = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv.s1) v1 <= pixel_valid;
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
    end
  end

  rgbq_luma u_luma_tl (
    .clk   (clk),
    .adv   (adv),
    .red   (pixel_data.red_top_left),
    .green (pixel_data.green_top_left),
    .blue  (pixel_data.blue_top_left),
    .luma  (ycc_data.luma_top_left)
  );

  rgbq_luma u_luma_tr (
    .clk   (clk),
    .adv   (adv),
    .red   (pixel_data.red_top_right),
    .green (pixel_data.green_top_right),
    .blue  (pixel_data.blue_top_right),
    .luma  (ycc_data.luma_top_right)
  );

  rgbq_luma u_luma_bl (
    .clk   (clk),
    .adv   (adv),
    .red   (pixel_data.red_bottom_left),
    .green (pixel_data.green_bottom_left),
    .blue  (pixel_data.blue_bottom_left),
    .luma  (ycc_data.luma_bottom_left)
  );

  rgbq_luma u_luma_br (
    .clk   (clk),
    .adv   (adv),
    .red   (pixel_data.red_bottom_right),
    .green (pixel_data.green_bottom_right),
    .blue  (pixel_data.blue_bottom_right),
    .luma  (ycc_data.luma_bottom_right)
  );

  rgbq_chroma u_chroma (
    .clk         (clk),
    .adv         (adv),
    .pix         (pixel_data),
    .chroma_blue (ycc_data.chroma_blue),
    .chroma_red  (ycc_data.chroma_red)
  );

endmodule

### rtl/rgbq_checker.sv
module rgbq_checker (
  input logic              clk,
  input logic              rst,
  input logic              pixel_valid,
  input logic              pixel_stall,
  input logic              ycc_valid,
  input logic              ycc_stall,
  input rgbq_pkg::ycc_t    ycc_data
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    ycc_valid && ycc_stall |=> ycc_valid)
    else $error("output valid dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    ycc_valid && ycc_stall |=> $stable(ycc_data))
    else $error("output payload changed under stall");

  // with no backpressure a transferred quad reaches the output through the stage registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall && !ycc_stall ##1 !ycc_stall ##1 !ycc_stall |=> ycc_valid)
    else $error("quad did not reach the output in three cycles");

  a_range: assert property (@(posedge clk) disable iff (rst)
    ycc_valid |->
      ycc_data.luma_top_left >= 8'd16 && ycc_data.luma_top_left <= 8'd235 &&
      ycc_data.luma_top_right >= 8'd16 && ycc_data.luma_top_right <= 8'd235 &&
      ycc_data.luma_bottom_left >= 8'd16 && ycc_data.luma_bottom_left <= 8'd235 &&
      ycc_data.luma_bottom_right >= 8'd16 && ycc_data.luma_bottom_right <= 8'd235 &&
      ycc_data.chroma_blue >= 8'd16 && ycc_data.chroma_blue <= 8'd239 &&
      ycc_data.chroma_red >= 8'd16 && ycc_data.chroma_red <= 8'd239)
    else $error("output outside studio range");

endmodule

bind rgb_quad_to_ycbcr_420_top rgbq_checker u_rgbq_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .ycc_valid   (ycc_valid),
  .ycc_stall   (ycc_stall),
  .ycc_data    (ycc_data)
);

### bench/tb_rgb_quad_to_ycbcr_420_top.sv
`timescale 1ns / 1ps

module tb_rgb_quad_to_ycbcr_420_top;

  localparam int RANDOM_QUADS   = 800;
  localparam int CALM_QUADS     = 150;
  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  class ycc_tracker;
    localparam int Y_R = 66;
    localparam int Y_G = 129;
    localparam int Y_B = 25;
    localparam int CB_R = 38;
    localparam int CB_G = 74;
    localparam int CB_B = 112;
    localparam int CR_R = 112;
    localparam int CR_G = 94;
    localparam int CR_B = 18;

    rgbq_pkg::ycc_t pending_ycc[$];
    int             mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic [7:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int acc;
      acc = Y_R * r + Y_G * g + Y_B * b;
      return 8'((acc >> 8) + 16);
    endfunction

    // floor division by 1024 on a signed sum, then the 128 offset
    function logic [7:0] chroma_of(int t);
      return 8'((t >>> 10) + 128);
    endfunction

    function rgbq_pkg::ycc_t ycc_from_quad(rgbq_pkg::pixel_t q);
      rgbq_pkg::ycc_t y;
      int sum_r, sum_g, sum_b;
      sum_r = int'(q.red_top_left) + int'(q.red_top_right)
            + int'(q.red_bottom_left) + int'(q.red_bottom_right);
      sum_g = int'(q.green_top_left) + int'(q.green_top_right)
            + int'(q.green_bottom_left) + int'(q.green_bottom_right);
      sum_b = int'(q.blue_top_left) + int'(q.blue_top_right)
            + int'(q.blue_bottom_left) + int'(q.blue_bottom_right);
      y.luma_top_left     = luma_of(q.red_top_left, q.green_top_left, q.blue_top_left);
      y.luma_top_right    = luma_of(q.red_top_right, q.green_top_right, q.blue_top_right);
      y.luma_bottom_left  = luma_of(q.red_bottom_left, q.green_bottom_left,
                                    q.blue_bottom_left);
      y.luma_bottom_right = luma_of(q.red_bottom_right, q.green_bottom_right,
                                    q.blue_bottom_right);
      y.chroma_blue = chroma_of(-CB_R * sum_r - CB_G * sum_g + CB_B * sum_b);
      y.chroma_red  = chroma_of(CR_R * sum_r - CR_G * sum_g - CR_B * sum_b);
      return y;
    endfunction

    function void note_quad(rgbq_pkg::pixel_t q);
      pending_ycc.push_back(ycc_from_quad(q));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_ycc(rgbq_pkg::ycc_t got);
      rgbq_pkg::ycc_t want;
      if (pending_ycc.size() == 0) begin
        $error("ycc transfer with no quad outstanding");
        mismatches++;
        return;
      end
      want = pending_ycc.pop_front();
      compare_field("luma_top_left", want.luma_top_left, got.luma_top_left);
      compare_field("luma_top_right", want.luma_top_right, got.luma_top_right);
      compare_field("luma_bottom_left", want.luma_bottom_left, got.luma_bottom_left);
      compare_field("luma_bottom_right", want.luma_bottom_right, got.luma_bottom_right);
      compare_field("chroma_blue", want.chroma_blue, got.chroma_blue);
      compare_field("chroma_red", want.chroma_red, got.chroma_red);
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             pixel_valid;
  logic             pixel_stall;
  rgbq_pkg::pixel_t pixel_data;
  logic             ycc_valid;
  logic             ycc_stall;
  rgbq_pkg::ycc_t   ycc_data;

  ycc_tracker tracker = new();
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  rgb_quad_to_ycbcr_420_top uut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_data  (pixel_data),
    .ycc_valid   (ycc_valid),
    .ycc_stall   (ycc_stall),
    .ycc_data    (ycc_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && !pixel_stall) begin
        tracker.note_quad(pixel_data);
      end
      if (ycc_valid && !ycc_stall) begin
        tracker.check_ycc(ycc_data);
      end
      if ((pixel_valid && !pixel_stall) || (ycc_valid && !ycc_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // output side: random stall bursts, one long hold on request
  initial begin
    ycc_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        ycc_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        ycc_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        ycc_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_quad(input rgbq_pkg::pixel_t q);
    pixel_valid <= 1'b1;
    pixel_data  <= q;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
  endtask

  task automatic idle_input(input int cycles);
    pixel_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic offer_quad(input rgbq_pkg::pixel_t q);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      idle_input($urandom_range(1, 19));
    end
    send_quad(q);
  endtask

  function automatic rgbq_pkg::pixel_t flat_quad(logic [7:0] r, logic [7:0] g,
                                                 logic [7:0] b);
    rgbq_pkg::pixel_t q;
    q.red_top_left      = r;
    q.green_top_left    = g;
    q.blue_top_left     = b;
    q.red_top_right     = r;
    q.green_top_right   = g;
    q.blue_top_right    = b;
    q.red_bottom_left   = r;
    q.green_bottom_left = g;
    q.blue_bottom_left  = b;
    q.red_bottom_right  = r;
    q.green_bottom_right = g;
    q.blue_bottom_right = b;
    return q;
  endfunction

  // mostly uniform channels, with the rails showing up often
  function automatic rgbq_pkg::pixel_t random_quad();
    rgbq_pkg::pixel_t q;
    for (int k = 0; k < 12; k++) begin
      case ($urandom_range(0, 7))
        0:       q[k*8 +: 8] = 8'd0;
        1:       q[k*8 +: 8] = 8'd255;
        default: q[k*8 +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return q;
  endfunction

  initial begin
    rgbq_pkg::pixel_t q;
    rst         <= 1'b1;
    pixel_valid <= 1'b0;
    pixel_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // rails, primaries and secondaries drive luma and chroma to their limits
    offer_quad(flat_quad(8'd0, 8'd0, 8'd0));
    offer_quad(flat_quad(8'd255, 8'd255, 8'd255));
    offer_quad(flat_quad(8'd255, 8'd0, 8'd0));
    offer_quad(flat_quad(8'd0, 8'd255, 8'd0));
    offer_quad(flat_quad(8'd0, 8'd0, 8'd255));
    offer_quad(flat_quad(8'd0, 8'd255, 8'd255));
    offer_quad(flat_quad(8'd255, 8'd0, 8'd255));
    offer_quad(flat_quad(8'd255, 8'd255, 8'd0));

    // one white pixel per corner, so a swapped luma position shows
    q = flat_quad(8'd0, 8'd0, 8'd0);
    q.red_top_left = 8'd255; q.green_top_left = 8'd255; q.blue_top_left = 8'd255;
    offer_quad(q);
    q = flat_quad(8'd0, 8'd0, 8'd0);
    q.red_top_right = 8'd255; q.green_top_right = 8'd255; q.blue_top_right = 8'd255;
    offer_quad(q);
    q = flat_quad(8'd0, 8'd0, 8'd0);
    q.red_bottom_left = 8'd255; q.green_bottom_left = 8'd255;
    q.blue_bottom_left = 8'd255;
    offer_quad(q);
    q = flat_quad(8'd0, 8'd0, 8'd0);
    q.red_bottom_right = 8'd255; q.green_bottom_right = 8'd255;
    q.blue_bottom_right = 8'd255;
    offer_quad(q);

    offer_quad(rgbq_pkg::pixel_t'({12{8'hAA}}));
    offer_quad(rgbq_pkg::pixel_t'({12{8'h55}}));

    // small negative chroma sums must round down, not toward zero
    q = flat_quad(8'd0, 8'd0, 8'd0);
    q.red_top_left = 8'd1;
    offer_quad(q);
    q = flat_quad(8'd0, 8'd0, 8'd0);
    q.blue_bottom_right = 8'd1;
    offer_quad(q);

    // input pauses until the pipeline has drained
    idle_input(1);
    while (tracker.pending_ycc.size() != 0) @(posedge clk);

    // back-to-back quads against a long output hold, fills all stages
    hold_request = 1'b1;
    while (hold_request) send_quad(random_quad());

    for (int i = 0; i < RANDOM_QUADS; i++) begin
      if (i == RANDOM_QUADS - CALM_QUADS) quiet = 1'b1;
      offer_quad(random_quad());
    end
    idle_input(1);

    while (tracker.pending_ycc.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
